FILE: design/aabb_pkg.sv
`default_nettype none

package aabb_pkg;

    localparam int COORD_W       = 32;
    localparam int SCALE_W       = 16;
    localparam int IDX_W         = 6;
    localparam int PROD_W        = COORD_W + SCALE_W;
    localparam int MAX_BOXES_DEF = 64;

    // command codes carried on the input tuser
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // one axis-aligned box, min corner then max corner
    typedef struct packed {
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] lo_z;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] hi_y;
        logic signed [COORD_W-1:0] hi_z;
    } box_t;

endpackage

`default_nettype wire

FILE: design/aabb_ram.sv
`default_nettype none

module aabb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                          wdata,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: design/aabb_cmp.sv
`default_nettype none

module aabb_cmp (
    input  wire aabb_pkg::box_t qry,
    input  wire aabb_pkg::box_t ent,
    output logic                hit
);

    logic sep_x;
    logic sep_y;
    logic sep_z;

    // separated when apart or when faces only touch; touching faces count as separated
    always_comb
    begin
        sep_x = ($signed(qry.hi_x) <= $signed(ent.lo_x)) || ($signed(qry.lo_x) >= $signed(ent.hi_x));
        sep_y = ($signed(qry.hi_y) <= $signed(ent.lo_y)) || ($signed(qry.lo_y) >= $signed(ent.hi_y));
        sep_z = ($signed(qry.hi_z) <= $signed(ent.lo_z)) || ($signed(qry.lo_z) >= $signed(ent.hi_z));
        hit   = !(sep_x || sep_y || sep_z);
    end

endmodule

`default_nettype wire

FILE: design/aabb_overlap_filter.sv
`default_nettype none

// Broad-phase box filter. A clear word empties the box store, a load word
// appends one box (min and max corner, Q16.16) and answers with the slot it
// took, or with store_full set once MAX_BOXES boxes are held. A query word
// brings three triangle vertices; the block forms their bounding box, widens
// it on every side by the smallest extent times margin_scale (Q0.16), with
// saturation, and then walks the store in order, returning the index of each
// box that overlaps it on every axis (touching faces do not count), tlast on
// the final one, or a single miss word when none qualifies. A load, like a
// query, ends by waiting for room on the output. A query forms the bounds,
// then the extents, the smallest extent, one 32x16 multiply and the widening,
// and then streams the stored boxes through the single compare unit reading
// the single-port box memory, reading the next box while testing the current
// one and holding when the output side stalls; it then tests the last box,
// leaves the walk and flushes. An empty store skips the walk. The input is not
// ready until the item is finished. margin_scale may be written only while
// the block is idle.

module aabb_overlap_filter #(
    parameter int MAX_BOXES = aabb_pkg::MAX_BOXES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         margin_scale_wr_en,
    input  wire logic [15:0]  margin_scale_wr_data,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pt_a_x, pt_a_y, pt_a_z, pt_b_x, pt_b_y, pt_b_z, pt_c_x, pt_c_y, pt_c_z
    input  wire logic [287:0] s_axis_tdata,
    // cmd
    input  wire logic [1:0]   s_axis_tuser,

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // box_index, zero padded to 8 bits
    output logic [7:0]        m_axis_tdata,
    // hit, store_full
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam int CW     = aabb_pkg::COORD_W;
    localparam int SW     = aabb_pkg::SCALE_W;
    localparam int PW     = aabb_pkg::PROD_W;
    localparam int IW     = aabb_pkg::IDX_W;
    localparam int AW     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int NW     = $clog2(MAX_BOXES + 1);
    localparam int BOX_W  = $bits(aabb_pkg::box_t);
    localparam logic [NW-1:0] MAX_CNT = NW'(MAX_BOXES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXT,
        ST_MINE,
        ST_MUL,
        ST_WIDEN,
        ST_WALK,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;

    logic [NW-1:0]        count_reg, count_next;
    logic [SW-1:0]        scale_reg, scale_next;
    logic signed [CW-1:0] lo_reg [3];
    logic signed [CW-1:0] lo_next [3];
    logic signed [CW-1:0] hi_reg [3];
    logic signed [CW-1:0] hi_next [3];
    logic [CW-1:0]        ext_reg [3];
    logic [CW-1:0]        ext_next [3];
    logic [CW-1:0]        emin_reg, emin_next;
    logic [PW-1:0]        prod_reg, prod_next;

    logic [NW-1:0]        rd_cnt_reg, rd_cnt_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]        cmp_idx_reg, cmp_idx_next;

    logic                 pend_valid_reg, pend_valid_next;
    logic [AW-1:0]        pend_idx_reg, pend_idx_next;
    logic                 pend_hit_reg, pend_hit_next;
    logic                 pend_full_reg, pend_full_next;

    logic                 out_valid_reg, out_valid_next;
    logic [IW-1:0]        out_idx_reg, out_idx_next;
    logic                 out_hit_reg, out_hit_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_full_reg, out_full_next;

    logic signed [CW-1:0] pt [9];
    logic                 s_accept;
    logic                 out_free;
    logic                 rd_more;
    logic                 stall;
    logic [CW-1:0]        margin;
    logic signed [CW+1:0] wide_lo [3];
    logic signed [CW+1:0] wide_hi [3];

    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    aabb_pkg::box_t       ram_wdata;
    logic [BOX_W-1:0]     ram_rdata;
    aabb_pkg::box_t       qbox;
    logic                 box_hit;

    function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // clamp a 34-bit sum back into the signed 32-bit range
    function automatic logic signed [CW-1:0] sat(input logic signed [CW+1:0] v);
        logic signed [CW-1:0] r;
        if ((v[CW+1] == v[CW]) && (v[CW] == v[CW-1]))
        begin
            r = v[CW-1:0];
        end
        else if (v[CW+1])
        begin
            r = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            pt[i] = s_axis_tdata[i*CW +: CW];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign rd_more       = (rd_cnt_reg < count_reg);
    assign stall         = cmp_valid_reg && box_hit && pend_valid_reg && !out_free;
    assign margin        = prod_reg[PW-1:SW];

    always_comb
    begin
        ram_wdata.lo_x = pt[0];
        ram_wdata.lo_y = pt[1];
        ram_wdata.lo_z = pt[2];
        ram_wdata.hi_x = pt[3];
        ram_wdata.hi_y = pt[4];
        ram_wdata.hi_z = pt[5];
        qbox.lo_x      = lo_reg[0];
        qbox.lo_y      = lo_reg[1];
        qbox.lo_z      = lo_reg[2];
        qbox.hi_x      = hi_reg[0];
        qbox.hi_y      = hi_reg[1];
        qbox.hi_z      = hi_reg[2];
        for (int a = 0; a < 3; a++)
        begin
            wide_lo[a] = {{2{lo_reg[a][CW-1]}}, lo_reg[a]} - {2'b00, margin};
            wide_hi[a] = {{2{hi_reg[a][CW-1]}}, hi_reg[a]} + {2'b00, margin};
        end
    end

    aabb_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    aabb_cmp u_cmp (
        .qry (qbox),
        .ent (aabb_pkg::box_t'(ram_rdata)),
        .hit (box_hit)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scale_next      = scale_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        ext_next        = ext_reg;
        emin_next       = emin_reg;
        prod_next       = prod_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_hit_next   = pend_hit_reg;
        pend_full_next  = pend_full_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_idx_next    = out_idx_reg;
        out_hit_next    = out_hit_reg;
        out_last_next   = out_last_reg;
        out_full_next   = out_full_reg;
        ram_we          = 1'b0;
        ram_addr        = cmp_idx_reg;

        if (margin_scale_wr_en)
        begin
            scale_next = margin_scale_wr_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                ram_addr = count_reg[AW-1:0];
                if (s_accept)
                begin
                    case (s_axis_tuser)
                        aabb_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        aabb_pkg::CMD_LOAD:
                        begin
                            pend_valid_next = 1'b1;
                            pend_hit_next   = 1'b0;
                            if (count_reg >= MAX_CNT)
                            begin
                                pend_idx_next  = '0;
                                pend_full_next = 1'b1;
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                pend_idx_next  = count_reg[AW-1:0];
                                pend_full_next = 1'b0;
                                count_next     = count_reg + NW'(1);
                            end
                            state_next = ST_FLUSH;
                        end
                        aabb_pkg::CMD_QUERY:
                        begin
                            for (int a = 0; a < 3; a++)
                            begin
                                lo_next[a] = smin(smin(pt[a], pt[3+a]), pt[6+a]);
                                hi_next[a] = smax(smax(pt[a], pt[3+a]), pt[6+a]);
                            end
                            pend_valid_next = 1'b0;
                            state_next      = ST_EXT;
                        end
                        default:
                        begin
                            // unused command: drop the word
                        end
                    endcase
                end
            end

            ST_EXT:
            begin
                // hi >= lo, so the difference fits unsigned in 32 bits
                for (int a = 0; a < 3; a++)
                begin
                    ext_next[a] = hi_reg[a] - lo_reg[a];
                end
                state_next = ST_MINE;
            end

            ST_MINE:
            begin
                emin_next = (ext_reg[0] < ext_reg[1]) ? ext_reg[0] : ext_reg[1];
                if (ext_reg[2] < emin_next)
                begin
                    emin_next = ext_reg[2];
                end
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                prod_next  = PW'(emin_reg) * PW'(scale_reg);
                state_next = ST_WIDEN;
            end

            ST_WIDEN:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    lo_next[a] = sat(wide_lo[a]);
                    hi_next[a] = sat(wide_hi[a]);
                end
                rd_cnt_next    = '0;
                cmp_valid_next = 1'b0;
                state_next     = (count_reg == '0) ? ST_FLUSH : ST_WALK;
            end

            ST_WALK:
            begin
                if (!stall)
                begin
                    // advance: read the next box while testing the current one
                    ram_addr       = rd_cnt_reg[AW-1:0];
                    cmp_valid_next = rd_more;
                    cmp_idx_next   = rd_cnt_reg[AW-1:0];
                    if (rd_more)
                    begin
                        rd_cnt_next = rd_cnt_reg + NW'(1);
                    end
                    if (cmp_valid_reg && box_hit)
                    begin
                        // hold the newest hit back so that the final one can carry tlast
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_idx_next   = IW'(pend_idx_reg);
                            out_hit_next   = 1'b1;
                            out_last_next  = 1'b0;
                            out_full_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = cmp_idx_reg;
                        pend_hit_next   = 1'b1;
                        pend_full_next  = 1'b0;
                    end
                    if (!cmp_valid_reg && !rd_more)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_idx_next  = IW'(pend_idx_reg);
                        out_hit_next  = pend_hit_reg;
                        out_full_next = pend_full_reg;
                    end
                    else
                    begin
                        // query with no overlap: one miss word
                        out_idx_next  = '0;
                        out_hit_next  = 1'b0;
                        out_full_next = 1'b0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            scale_reg      <= '0;
            rd_cnt_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scale_reg      <= scale_next;
            rd_cnt_reg     <= rd_cnt_next;
            cmp_valid_reg  <= cmp_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        ext_reg       <= ext_next;
        emin_reg      <= emin_next;
        prod_reg      <= prod_next;
        cmp_idx_reg   <= cmp_idx_next;
        pend_idx_reg  <= pend_idx_next;
        pend_hit_reg  <= pend_hit_next;
        pend_full_reg <= pend_full_next;
        out_idx_reg   <= out_idx_next;
        out_hit_reg   <= out_hit_next;
        out_last_reg  <= out_last_next;
        out_full_reg  <= out_full_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(8-IW){1'b0}}, out_idx_reg};
    assign m_axis_tuser  = {out_full_reg, out_hit_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int          BOX_SLOTS    = aabb_pkg::MAX_BOXES_DEF;
    localparam int          IW           = aabb_pkg::IDX_W;
    localparam logic [1:0]  CMD_NONE     = 2'd3;   // unused code, block ignores it
    localparam int          Q_ONE        = 32'h0001_0000;
    localparam int          C_MAX        = 32'h7FFF_FFFF;
    localparam int          C_MIN        = 32'h8000_0000;
    localparam int          SPAN         = 32'h0004_0000;
    localparam longint      SAT_HI       = 64'sd2147483647;
    localparam longint      SAT_LO       = -64'sd2147483648;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          RANDOM_WORDS = 300;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    typedef int coord_set_t [9];

    // one result word as it should leave the block
    typedef struct packed {
        logic [IW-1:0] idx;
        logic          hit;
        logic          last;
        logic          full;
    } hit_word_t;

    typedef enum logic [1:0] {RX_OPEN, RX_TOGGLE, RX_RANDOM, RX_RUNS} rx_mode_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         margin_scale_wr_en = 1'b0;
    logic [15:0]  margin_scale_wr_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = aabb_pkg::CMD_CLEAR;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    // shadow of the box store and the scale register
    int           shadow_lo [BOX_SLOTS][3];
    int           shadow_hi [BOX_SLOTS][3];
    int           stored_boxes = 0;
    logic [15:0]  scale_shadow = '0;

    hit_word_t    pending_indices [$];
    int           mismatches = 0;
    int           word_count = 0;
    int           burst_left = 0;
    bit           gaps_off = 1'b0;
    int unsigned  cycle_count = 0;
    int           stall_phase = 0;
    int           stall_run = 0;
    rx_mode_t     rx_mode = RX_OPEN;

    aabb_overlap_filter #(
        .MAX_BOXES (BOX_SLOTS)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .margin_scale_wr_en   (margin_scale_wr_en),
        .margin_scale_wr_data (margin_scale_wr_data),
        .s_axis_tvalid        (s_axis_tvalid),
        .s_axis_tready        (s_axis_tready),
        .s_axis_tdata         (s_axis_tdata),
        .s_axis_tuser         (s_axis_tuser),
        .m_axis_tvalid        (m_axis_tvalid),
        .m_axis_tready        (m_axis_tready),
        .m_axis_tdata         (m_axis_tdata),
        .m_axis_tuser         (m_axis_tuser),
        .m_axis_tlast         (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs or drops a word.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: switch at random between open, toggling, random and stall-run
    // patterns so that back-pressure lands on every phase of a query.
    always @(posedge clk)
    begin
        stall_phase++;
        if (stall_phase % 97 == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_TOGGLE: m_axis_tready <= stall_phase[0];
            RX_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
            default:
            begin
                if (stall_run > 0)
                begin
                    stall_run--;
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_run = $urandom_range(1, 6);
                end
            end
        endcase
    end

    // Compare every accepted result word with the oldest one predicted.
    always @(posedge clk)
    begin : check_results
        hit_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_indices.size() == 0)
            begin
                $display("%0t: unpredicted word, tdata %h tuser %b tlast %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want = pending_indices.pop_front();
                if (m_axis_tdata !== {2'b00, want.idx})
                begin
                    $display("%0t: box_index expected %h actual %h",
                             $time, {2'b00, want.idx}, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tuser[0] !== want.hit)
                begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, m_axis_tuser[0]);
                    mismatches++;
                end
                if (m_axis_tuser[1] !== want.full)
                begin
                    $display("%0t: store_full expected %b actual %b",
                             $time, want.full, m_axis_tuser[1]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: tlast expected %b actual %b", $time, want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Append one predicted word at the tail of the queue.
    function automatic void predict_word(input logic [IW-1:0] idx, input logic hit,
                                         input logic last, input logic full);
        hit_word_t w;
        w.idx  = idx;
        w.hit  = hit;
        w.last = last;
        w.full = full;
        pending_indices.insert(pending_indices.size(), w);
    endfunction

    // Work out the words one accepted input word causes and update the shadow
    // store. A query widens the triangle box by floor(smallest extent * scale / 2^16),
    // clamps to 32 bits and keeps every box that overlaps it on all three axes.
    function automatic void filter_word(input logic [1:0] cmd, input coord_set_t p);
        longint lo [3];
        longint hi [3];
        longint ext;
        longint mrg;
        int     a;
        int     b;
        int     found;
        bit     sep;
        case (cmd)
            aabb_pkg::CMD_CLEAR: stored_boxes = 0;
            aabb_pkg::CMD_LOAD:
            begin
                if (stored_boxes >= BOX_SLOTS)
                    predict_word('0, 1'b0, 1'b1, 1'b1);
                else
                begin
                    for (a = 0; a < 3; a++)
                    begin
                        shadow_lo[stored_boxes][a] = p[a];
                        shadow_hi[stored_boxes][a] = p[3 + a];
                    end
                    predict_word(IW'(stored_boxes), 1'b0, 1'b1, 1'b0);
                    stored_boxes++;
                end
            end
            aabb_pkg::CMD_QUERY:
            begin
                for (a = 0; a < 3; a++)
                begin
                    lo[a] = p[a];
                    hi[a] = p[a];
                    for (b = 1; b < 3; b++)
                    begin
                        if (p[3 * b + a] < lo[a]) lo[a] = p[3 * b + a];
                        if (p[3 * b + a] > hi[a]) hi[a] = p[3 * b + a];
                    end
                end
                ext = hi[0] - lo[0];
                if (hi[1] - lo[1] < ext) ext = hi[1] - lo[1];
                if (hi[2] - lo[2] < ext) ext = hi[2] - lo[2];
                mrg = (ext * longint'(scale_shadow)) >>> 16;
                for (a = 0; a < 3; a++)
                begin
                    lo[a] = lo[a] - mrg;
                    hi[a] = hi[a] + mrg;
                    if (lo[a] < SAT_LO) lo[a] = SAT_LO;
                    if (hi[a] > SAT_HI) hi[a] = SAT_HI;
                end
                found = 0;
                for (b = 0; b < stored_boxes; b++)
                begin
                    sep = 1'b0;
                    for (a = 0; a < 3; a++)
                        if (hi[a] <= shadow_lo[b][a] || lo[a] >= shadow_hi[b][a])
                            sep = 1'b1;
                    if (!sep)
                    begin
                        predict_word(IW'(b), 1'b1, 1'b0, 1'b0);
                        found++;
                    end
                end
                if (found == 0)
                    predict_word('0, 1'b0, 1'b1, 1'b0);
                else
                    pending_indices[pending_indices.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Offer one word, in bursts with random gaps between them, and hold it
    // until the block takes it.
    task automatic send_word(input logic [1:0] cmd, input coord_set_t p);
        int           gap;
        int           i;
        logic [287:0] packed_pts;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_off ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        for (i = 0; i < 9; i++)
            packed_pts[32 * i +: 32] = p[i];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= packed_pts;
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        filter_word(cmd, p);
        burst_left--;
        if (cmd != CMD_NONE)
            word_count++;
    endtask

    // Drop valid, wait for every predicted word, then let a clear or a long
    // query walk finish before anything touches the register.
    task automatic drain_filter();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_indices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_margin_scale(input logic [15:0] value);
        drain_filter();
        margin_scale_wr_en   <= 1'b1;
        margin_scale_wr_data <= value;
        @(posedge clk);
        margin_scale_wr_en   <= 1'b0;
        scale_shadow = value;
    endtask

    function automatic coord_set_t corners(input int ax, input int ay, input int az,
                                           input int bx, input int by, input int bz,
                                           input int cx, input int cy, input int cz);
        coord_set_t p;
        p = '{ax, ay, az, bx, by, bz, cx, cy, cz};
        return p;
    endfunction

    function automatic coord_set_t noise_word();
        coord_set_t p;
        int         i;
        for (i = 0; i < 9; i++)
            p[i] = int'($urandom);
        return p;
    endfunction

    // Box in a small window (often on a quarter-unit grid so faces meet
    // exactly) or anywhere; now and then with min and max swapped.
    function automatic coord_set_t make_box(input bit wide);
        coord_set_t p;
        int         a;
        int         t;
        int         size;
        p = noise_word();
        for (a = 0; a < 3; a++)
        begin
            if (wide)
            begin
                if (p[a] > p[3 + a])
                begin
                    t = p[a];
                    p[a] = p[3 + a];
                    p[3 + a] = t;
                end
            end
            else
            begin
                p[a] = int'($urandom_range(0, 2 * SPAN)) - SPAN;
                size = int'($urandom_range(0, SPAN / 2));
                if ($urandom_range(0, 1) == 0)
                begin
                    p[a] = p[a] & ~32'h3FFF;
                    size = size & ~32'h3FFF;
                end
                p[3 + a] = p[a] + size;
            end
            if ($urandom_range(0, 11) == 0)
            begin
                t = p[a];
                p[a] = p[3 + a];
                p[3 + a] = t;
            end
        end
        return p;
    endfunction

    // Triangle scattered round a random centre, or anywhere; sometimes one
    // coordinate pinned to an end of the range to drive saturation.
    function automatic coord_set_t make_triangle(input bit wide);
        coord_set_t p;
        int         a;
        int         v;
        int         centre;
        p = noise_word();
        if (!wide)
            for (a = 0; a < 3; a++)
            begin
                centre = int'($urandom_range(0, 2 * SPAN)) - SPAN;
                for (v = 0; v < 3; v++)
                begin
                    p[3 * v + a] = centre + int'($urandom_range(0, SPAN / 2)) - SPAN / 4;
                    if ($urandom_range(0, 1) == 0)
                        p[3 * v + a] = p[3 * v + a] & ~32'h3FFF;
                end
            end
        if ($urandom_range(0, 9) == 0)
            p[$urandom_range(0, 8)] = ($urandom_range(0, 1) != 0) ? C_MAX : C_MIN;
        return p;
    endfunction

    // Query on an empty store, the unused code and a clear with nothing held.
    task automatic test_empty_store();
        send_word(aabb_pkg::CMD_QUERY, corners(0, 0, 0, Q_ONE, Q_ONE, Q_ONE, 0, Q_ONE, 0));
        send_word(CMD_NONE, noise_word());
        send_word(aabb_pkg::CMD_CLEAR, noise_word());
        send_word(aabb_pkg::CMD_QUERY, corners(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                                               0, 0, 0));
        drain_filter();
    endtask

    // Faces that only touch, a one-lsb overlap, an inverted box, a point box
    // at the top of the range and a box spanning everything, at zero margin.
    task automatic test_box_edges();
        send_word(aabb_pkg::CMD_LOAD, corners(0, 0, 0, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0));
        send_word(aabb_pkg::CMD_QUERY, corners(-Q_ONE, 0, 0, 0, Q_ONE, Q_ONE,
                                               -Q_ONE / 2, Q_ONE / 2, Q_ONE / 2));
        send_word(aabb_pkg::CMD_QUERY, corners(Q_ONE, 0, 0, 2 * Q_ONE, Q_ONE, Q_ONE,
                                               Q_ONE, Q_ONE / 2, 0));
        send_word(aabb_pkg::CMD_QUERY, corners(-Q_ONE, 0, 0, 1, Q_ONE, Q_ONE,
                                               0, 0, Q_ONE / 2));
        send_word(aabb_pkg::CMD_LOAD, corners(3 * Q_ONE, 3 * Q_ONE, 3 * Q_ONE,
                                              2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE, 0, 0, 0));
        send_word(aabb_pkg::CMD_QUERY, corners(Q_ONE, Q_ONE, Q_ONE,
                                               4 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE,
                                               2 * Q_ONE, Q_ONE, 3 * Q_ONE));
        send_word(aabb_pkg::CMD_LOAD, corners(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                                              0, 0, 0));
        send_word(aabb_pkg::CMD_LOAD, corners(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                                              0, 0, 0));
        send_word(aabb_pkg::CMD_QUERY, corners(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                                               C_MAX, C_MAX, C_MAX));
        send_word(aabb_pkg::CMD_QUERY, corners(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                                               C_MIN, C_MAX, 0));
        send_word(aabb_pkg::CMD_QUERY, corners(Q_ONE / 2, Q_ONE / 2, Q_ONE / 2,
                                               Q_ONE / 2, Q_ONE / 2, Q_ONE / 2,
                                               Q_ONE / 2, Q_ONE / 2, Q_ONE / 2));
        drain_filter();
    endtask

    // Margin of one lsb turning a touch into a hit, full-scale widening that
    // clamps at both ends, and a flat triangle whose margin is zero.
    task automatic test_margin_widening();
        set_margin_scale(16'd1);
        send_word(aabb_pkg::CMD_QUERY, corners(-2 * Q_ONE, 0, 0, 0, 2 * Q_ONE, Q_ONE,
                                               -Q_ONE, Q_ONE, 0));
        set_margin_scale(16'hFFFF);
        send_word(aabb_pkg::CMD_QUERY, corners(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                                               0, 0, 0));
        send_word(aabb_pkg::CMD_QUERY, corners(C_MAX - Q_ONE, C_MAX - Q_ONE, C_MAX - Q_ONE,
                                               C_MAX, C_MAX, C_MAX,
                                               C_MAX, C_MAX - Q_ONE, C_MAX));
        send_word(aabb_pkg::CMD_QUERY, corners(C_MIN, C_MIN, C_MIN,
                                               C_MIN + Q_ONE, C_MIN + Q_ONE, C_MIN + Q_ONE,
                                               C_MIN, C_MIN + Q_ONE, C_MIN));
        set_margin_scale(16'h8000);
        send_word(aabb_pkg::CMD_QUERY, corners(0, -Q_ONE, Q_ONE / 2, 2 * Q_ONE, Q_ONE,
                                               Q_ONE / 2, Q_ONE, 0, Q_ONE / 2));
        drain_filter();
    endtask

    // Fill every slot, hit them all in one query, then get loads refused.
    task automatic test_store_full();
        set_margin_scale(16'd0);
        send_word(aabb_pkg::CMD_CLEAR, noise_word());
        repeat (BOX_SLOTS) send_word(aabb_pkg::CMD_LOAD, make_box(1'b0));
        send_word(aabb_pkg::CMD_QUERY, corners(-2 * SPAN, -2 * SPAN, -2 * SPAN,
                                               2 * SPAN, 2 * SPAN, 2 * SPAN, 0, 0, 0));
        send_word(aabb_pkg::CMD_LOAD, make_box(1'b0));
        send_word(aabb_pkg::CMD_LOAD, noise_word());
        send_word(aabb_pkg::CMD_QUERY, make_triangle(1'b0));
        send_word(aabb_pkg::CMD_CLEAR, noise_word());
        send_word(aabb_pkg::CMD_LOAD, make_box(1'b0));
        drain_filter();
    endtask

    // Rounds of clear, loads and queries with random content; a scale change
    // every fourth round, some noise and the odd run that overfills the store.
    task automatic test_random_traffic();
        int  first_word;
        int  round_no;
        int  n_load;
        int  n_query;
        bit  wide;
        first_word = word_count;
        round_no = 0;
        while (word_count - first_word < RANDOM_WORDS)
        begin
            if (round_no % 4 == 3)
                case ($urandom_range(0, 3))
                    0:       set_margin_scale(16'd0);
                    1:       set_margin_scale(16'hFFFF);
                    default: set_margin_scale(16'($urandom));
                endcase
            gaps_off = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) != 0)
                send_word(aabb_pkg::CMD_CLEAR, noise_word());
            n_load = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 10);
            wide = ($urandom_range(0, 5) == 0);
            repeat (n_load) send_word(aabb_pkg::CMD_LOAD, make_box(wide));
            n_query = $urandom_range(2, 8);
            repeat (n_query)
            begin
                send_word(aabb_pkg::CMD_QUERY,
                          make_triangle(wide || $urandom_range(0, 9) == 0));
                if ($urandom_range(0, 7) == 0)
                    send_word(CMD_NONE, noise_word());
            end
            round_no++;
        end
        gaps_off = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_store();
        test_box_edges();
        test_margin_widening();
        test_store_full();
        test_random_traffic();
        drain_filter();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
design/aabb_pkg.sv
design/aabb_ram.sv
design/aabb_cmp.sv
design/aabb_overlap_filter.sv
dv/testbench.sv
